/* hw/rtl/mlsm_pkg.sv */
package mlsm_pkg;

    // Operation codes carried on the cmd field
    localparam logic [2:0] CMD_LB  = 3'd0;
    localparam logic [2:0] CMD_LBU = 3'd1;
    localparam logic [2:0] CMD_LH  = 3'd2;
    localparam logic [2:0] CMD_LHU = 3'd3;
    localparam logic [2:0] CMD_LW  = 3'd4;
    localparam logic [2:0] CMD_SB  = 3'd5;
    localparam logic [2:0] CMD_SH  = 3'd6;
    localparam logic [2:0] CMD_SW  = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNALIGNED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // write zero at the sweep pointer and advance it
        logic load;    // capture the request and form the effective address
        logic lookup;  // check the address, start the word read
        logic merge;   // extract load data, write back store data
        logic put;     // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;  // sweep pointer sits on the last word
        logic out_free;    // output register can take a result this cycle
    } t_dp_status;

endpackage

/* hw/rtl/mlsm_ram.sv */
module mlsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mlsm_ctrl.sv */
module mlsm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mlsm_pkg::t_dp_status i_status,
    output mlsm_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_MERGE  = 5'b01000,
        S_PUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_PUT;
            end
            S_PUT: begin
                o_cmd.put = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

/* hw/rtl/mlsm_dp.sv */
module mlsm_dp #(
    parameter int MEM_WORDS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mlsm_pkg::t_dp_cmd    i_cmd,
    output mlsm_pkg::t_dp_status o_dp_status,
    input  logic [2:0]           i_req_cmd,
    input  logic [31:0]          i_base_address,
    input  logic signed [15:0]   i_offset,
    input  logic signed [31:0]   i_store_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic signed [31:0]   o_load_data,
    output logic [1:0]           o_status
);

    localparam int          AW    = $clog2(MEM_WORDS);
    localparam logic [32:0] LIMIT = 33'(MEM_WORDS * 4);

    // request registers
    logic [2:0]  r_op;
    logic [31:0] r_ea;
    logic [31:0] r_data;
    logic [1:0]  r_chk;
    logic [31:0] r_result;

    // clear sweep
    logic [AW-1:0] r_clr_idx;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_status;

    logic [1:0]  n_chk;
    logic [1:0]  align_mask;
    logic [31:0] ram_rdata;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0] ram_wdata;
    logic [4:0]  lane_sh;
    logic [7:0]  byte_sel;
    logic [15:0] half_sel;
    logic [31:0] n_result;
    logic [31:0] store_word;
    logic        is_store;

    // alignment and range check
    always_comb begin
        case (r_op) inside
            mlsm_pkg::CMD_LH, mlsm_pkg::CMD_LHU, mlsm_pkg::CMD_SH: align_mask = 2'b01;
            mlsm_pkg::CMD_LW, mlsm_pkg::CMD_SW:                    align_mask = 2'b11;
            default:                                               align_mask = 2'b00;
        endcase
        if ((r_ea[1:0] & align_mask) != 2'b00) begin
            n_chk = mlsm_pkg::ST_UNALIGNED;
        end else if ({1'b0, r_ea} >= LIMIT) begin
            n_chk = mlsm_pkg::ST_RANGE;
        end else begin
            n_chk = mlsm_pkg::ST_OK;
        end
    end

    // lane extraction and store merge
    assign lane_sh  = {r_ea[1:0], 3'b000};
    assign byte_sel = 8'(ram_rdata >> lane_sh);
    assign half_sel = r_ea[1] ? ram_rdata[31:16] : ram_rdata[15:0];

    always_comb begin
        n_result   = '0;
        store_word = r_data;
        is_store   = 1'b0;
        unique case (r_op)
            mlsm_pkg::CMD_LB:  n_result = {{24{byte_sel[7]}}, byte_sel};
            mlsm_pkg::CMD_LBU: n_result = {24'd0, byte_sel};
            mlsm_pkg::CMD_LH:  n_result = {{16{half_sel[15]}}, half_sel};
            mlsm_pkg::CMD_LHU: n_result = {16'd0, half_sel};
            mlsm_pkg::CMD_LW:  n_result = ram_rdata;
            mlsm_pkg::CMD_SB: begin
                is_store   = 1'b1;
                store_word = (ram_rdata & ~(32'h0000_00ff << lane_sh))
                           | ({24'd0, r_data[7:0]} << lane_sh);
            end
            mlsm_pkg::CMD_SH: begin
                is_store   = 1'b1;
                store_word = (ram_rdata & ~(32'h0000_ffff << lane_sh))
                           | ({16'd0, r_data[15:0]} << lane_sh);
            end
            mlsm_pkg::CMD_SW: begin
                is_store   = 1'b1;
                store_word = r_data;
            end
            default: n_result = '0;
        endcase
        if (r_chk != mlsm_pkg::ST_OK) begin
            n_result = '0;
        end
    end

    // write port: clear sweep or store write-back
    always_comb begin
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.merge && is_store && (r_chk == mlsm_pkg::ST_OK);
            ram_waddr = r_ea[AW+1:2];
            ram_wdata = store_word;
        end
    end

    mlsm_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_ea[AW+1:2]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req_cmd;
            r_ea   <= i_base_address + {{16{i_offset[15]}}, $unsigned(i_offset)};
            r_data <= $unsigned(i_store_data);
        end
        if (i_cmd.lookup) begin
            r_chk <= n_chk;
        end
        if (i_cmd.merge) begin
            r_result <= n_result;
        end
        if (i_cmd.put) begin
            r_out_data   <= r_result;
            r_out_status <= r_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_dp_status.clear_last = (r_clr_idx == AW'(MEM_WORDS - 1));
    assign o_dp_status.out_free   = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_load_data = $signed(r_out_data);
    assign o_status    = r_out_status;

endmodule

/* hw/rtl/mips_load_store_memory_core.sv */
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_cmd, i_base_address, i_offset, i_store_data
// result    out        o_valid / i_stall  o_load_data, o_status
//
// A request passes through capture and address add, range/alignment check with the word
// read, lane merge with write-back, and output load, in that order. The next request is
// taken only once the last result has moved into the output register.
// After reset a sweep writes zero to all MEM_WORDS words, one per cycle, with o_stall
// held high; requests are accepted once it ends.
// A stalled result holds in the output register; the next request may enter, then waits
// in its output step until the register frees.
module mips_load_store_memory_core #(
    parameter int MEM_WORDS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic [31:0]        i_base_address,
    input  logic signed [15:0] i_offset,
    input  logic signed [31:0] i_store_data,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_load_data,
    output logic [1:0]         o_status
);

    // command and status between controller and datapath
    mlsm_pkg::t_dp_cmd    dp_cmd;
    mlsm_pkg::t_dp_status dp_status;

    // sequence clear, capture, check, merge and output
    mlsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_status(dp_status),
        .o_cmd   (dp_cmd)
    );

    // hold the word store, form the address and extract or merge lanes
    mlsm_dp #(
        .MEM_WORDS(MEM_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_dp_status   (dp_status),
        .i_req_cmd     (i_cmd),
        .i_base_address(i_base_address),
        .i_offset      (i_offset),
        .i_store_data  (i_store_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_load_data   (o_load_data),
        .o_status      (o_status)
    );

endmodule

/* tb/sv/tb_mips_load_store_memory_core.sv */
module tb_mips_load_store_memory_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_WORDS = 4096;
    localparam int AW = $clog2(MEM_WORDS);
    localparam int unsigned MEM_BYTES = 4 * MEM_WORDS;

    // What one request should produce on the result channel
    typedef struct packed {
        logic [31:0] load_data;
        logic [1:0]  status;
    } t_access_result;

    // All inputs start at known values
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [2:0]         i_cmd = mlsm_pkg::CMD_LB;
    logic [31:0]        i_base_address = '0;
    logic signed [15:0] i_offset = '0;
    logic signed [31:0] i_store_data = '0;
    logic               i_stall = 1'b0;

    logic               o_stall;
    logic               o_valid;
    logic signed [31:0] o_load_data;
    logic [1:0]         o_status;

    // Shadow copy of the word memory, updated in request order
    logic [31:0]    mem_image [MEM_WORDS];
    t_access_result pending_results[$];

    int  fail_count = 0;
    int  requests_sent = 0;
    int  stores_sent = 0;
    int  results_seen = 0;
    int  status_seen [3] = '{0, 0, 0};
    int  backpressure_cycles = 0;

    // Traffic shaping shared between the sender and the result-side staller
    bit  calm_mode = 1'b0;
    int  holdoff_request = 0;

    mips_load_store_memory_core #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_base_address(i_base_address),
        .i_offset      (i_offset),
        .i_store_data  (i_store_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_load_data   (o_load_data),
        .o_status      (o_status)
    );

    always #1 i_clk = ~i_clk;

    // Alignment mask of an operation: halfwords need bit 0 clear, words bits 1:0
    function automatic logic [1:0] align_mask(input logic [2:0] cmd);
        case (cmd)
            mlsm_pkg::CMD_LH, mlsm_pkg::CMD_LHU, mlsm_pkg::CMD_SH: return 2'b01;
            mlsm_pkg::CMD_LW, mlsm_pkg::CMD_SW:                    return 2'b11;
            default:                                               return 2'b00;
        endcase
    endfunction

    // Perform one access on the shadow memory and return the result it should give.
    // Misalignment wins over out-of-range; errors write nothing and return zero.
    function automatic t_access_result apply_access(input logic [2:0] cmd,
                                                    input logic [31:0] base,
                                                    input logic signed [15:0] offset,
                                                    input logic [31:0] data);
        logic [31:0]    ea;
        logic [31:0]    word;
        logic [4:0]     shift;
        logic [7:0]     lane_b;
        logic [15:0]    lane_h;
        t_access_result res;
        ea = base + {{16{offset[15]}}, offset};
        res.load_data = '0;
        res.status = mlsm_pkg::ST_OK;
        if ((ea[1:0] & align_mask(cmd)) != 2'b00) begin
            res.status = mlsm_pkg::ST_UNALIGNED;
        end else if (ea >= MEM_BYTES) begin
            res.status = mlsm_pkg::ST_RANGE;
        end else begin
            word = mem_image[ea[AW+1:2]];
            shift = {ea[1:0], 3'b000};
            lane_b = word[shift +: 8];
            lane_h = word[shift +: 16];
            case (cmd)
                mlsm_pkg::CMD_LB:  res.load_data = {{24{lane_b[7]}}, lane_b};
                mlsm_pkg::CMD_LBU: res.load_data = {24'd0, lane_b};
                mlsm_pkg::CMD_LH:  res.load_data = {{16{lane_h[15]}}, lane_h};
                mlsm_pkg::CMD_LHU: res.load_data = {16'd0, lane_h};
                mlsm_pkg::CMD_LW:  res.load_data = word;
                mlsm_pkg::CMD_SB: begin
                    word[shift +: 8] = data[7:0];
                    mem_image[ea[AW+1:2]] = word;
                end
                mlsm_pkg::CMD_SH: begin
                    word[shift +: 16] = data[15:0];
                    mem_image[ea[AW+1:2]] = word;
                end
                default: mem_image[ea[AW+1:2]] = data;
            endcase
        end
        return res;
    endfunction

    // Offer one request, idling first now and then; return at the falling edge
    // after acceptance with valid still high, so the next call never toggles it
    // twice in one step.
    task automatic send_request(input logic [2:0] cmd, input logic [31:0] base,
                                input logic signed [15:0] offset, input logic [31:0] data);
        while (!calm_mode && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_base_address <= base;
        i_offset <= offset;
        i_store_data <= data;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        // Predict at acceptance so memory updates follow request order
        pending_results.push_back(apply_access(cmd, base, offset, data));
        requests_sent++;
        if (cmd inside {mlsm_pkg::CMD_SB, mlsm_pkg::CMD_SH, mlsm_pkg::CMD_SW}) begin
            stores_sent++;
        end
        @(negedge i_clk);
    endtask

    // Drive the result-side stall: random, off in calm stretches, and solid for a
    // counted hold-off when one is asked for.
    always @(negedge i_clk) begin : result_staller
        int hold_left;
        if (holdoff_request != 0) begin
            hold_left = holdoff_request;
            holdoff_request = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (calm_mode) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 25);
        end
    end

    // Compare every accepted result, field by field, against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_access_result want;
        if (i_rst_n && i_valid && o_stall) begin
            backpressure_cycles++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result with no request pending: load_data %h status %0d",
                         $realtime, o_load_data, o_status);
            end else begin
                want = pending_results.pop_front();
                if (want.status < 3) begin
                    status_seen[want.status]++;
                end
                if (o_load_data !== want.load_data) begin
                    fail_count++;
                    $display("%0t: load_data mismatch: expected %h actual %h",
                             $realtime, want.load_data, o_load_data);
                end
                if (o_status !== want.status) begin
                    fail_count++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $realtime, want.status, o_status);
                end
            end
        end
    end

    // Hand-picked requests: every operation, sign extension on every byte lane, zero
    // extension, partial stores, misalignment, the top of memory, both errors at once,
    // offset extremes and address wrap.
    task automatic test_directed_accesses();
        send_request(mlsm_pkg::CMD_LW,  32'd0, 16'sd0, 32'hDEAD_BEEF);  // cleared memory reads 0
        send_request(mlsm_pkg::CMD_SW,  32'd0, 16'sd0, 32'h80FF_7F01);
        send_request(mlsm_pkg::CMD_LB,  32'd0, 16'sd0, 32'd0);
        send_request(mlsm_pkg::CMD_LB,  32'd0, 16'sd1, 32'd0);
        send_request(mlsm_pkg::CMD_LB,  32'd0, 16'sd2, 32'd0);
        send_request(mlsm_pkg::CMD_LBU, 32'd0, 16'sd2, 32'd0);
        send_request(mlsm_pkg::CMD_LB,  32'd0, 16'sd3, 32'd0);
        send_request(mlsm_pkg::CMD_LH,  32'd0, 16'sd2, 32'd0);
        send_request(mlsm_pkg::CMD_LHU, 32'd0, 16'sd2, 32'd0);
        send_request(mlsm_pkg::CMD_LH,  32'd0, 16'sd0, 32'd0);
        // Partial stores touch only their lanes
        send_request(mlsm_pkg::CMD_SB,  32'd5, 16'sd0, 32'hFFFF_FFAB);
        send_request(mlsm_pkg::CMD_SH,  32'd4, 16'sd2, 32'h1234_5678);
        send_request(mlsm_pkg::CMD_LW,  32'd4, 16'sd0, 32'd0);
        // Misaligned halfword and word; the store must leave memory alone
        send_request(mlsm_pkg::CMD_LH,  32'd1, 16'sd0, 32'd0);
        send_request(mlsm_pkg::CMD_SW,  32'd2, 16'sd0, 32'hFFFF_FFFF);
        send_request(mlsm_pkg::CMD_LW,  32'd0, 16'sd0, 32'd0);
        send_request(mlsm_pkg::CMD_LW,  32'd6, 16'sd0, 32'd0);
        // Last word and last byte, then one past the end
        send_request(mlsm_pkg::CMD_SW,  MEM_BYTES - 4, 16'sd0, 32'h7FFF_FFFF);
        send_request(mlsm_pkg::CMD_LBU, MEM_BYTES - 1, 16'sd0, 32'd0);
        send_request(mlsm_pkg::CMD_LB,  MEM_BYTES, 16'sd0, 32'd0);
        send_request(mlsm_pkg::CMD_SW,  32'hFFFF_FFFC, 16'sd0, 32'h1111_1111);
        // Misaligned and out of range together
        send_request(mlsm_pkg::CMD_LW,  MEM_BYTES + 4, -16'sd3, 32'd0);
        // Offset extremes and wrap through 2^32
        send_request(mlsm_pkg::CMD_LW,  32'h0000_8000, 16'sh8000, 32'd0);
        send_request(mlsm_pkg::CMD_LBU, 32'd0, 16'sh7FFF, 32'd0);
        send_request(mlsm_pkg::CMD_LW,  32'hFFFF_FFFF, 16'sd5, 32'd0);
    endtask

    // Random requests. Half target a small hot window so loads see earlier stores,
    // the rest spread over all of memory, straddle its top, or go anywhere.
    // Base is derived from the chosen address and a random offset, so base wraps
    // and every bit of base and offset gets exercised.
    task automatic test_random_traffic(input int count, input int unsigned hot_bytes);
        logic [2:0]         cmd;
        logic [31:0]        ea;
        logic signed [15:0] offset;
        int                 pick;
        repeat (count) begin
            cmd = 3'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 50) begin
                ea = $urandom_range(hot_bytes - 1);
            end else if (pick < 75) begin
                ea = $urandom_range(MEM_BYTES - 1);
            end else if (pick < 87) begin
                ea = MEM_BYTES - 8 + $urandom_range(15);
            end else begin
                ea = $urandom;
            end
            // Keep most accesses aligned so they reach the memory
            if ($urandom_range(99) < 85) begin
                ea[1:0] = ea[1:0] & ~align_mask(cmd);
            end
            offset = 16'($urandom);
            send_request(cmd, ea - {{16{offset[15]}}, offset}, offset, $urandom);
        end
    endtask

    // Both sides flat out on a tiny window: back-to-back read-after-write hazards
    task automatic test_back_to_back();
        calm_mode = 1'b1;
        test_random_traffic(250, 16);
        calm_mode = 1'b0;
    endtask

    // Hold the result side for a long stretch while requests keep coming, so the
    // block fills and pushes back on its input
    task automatic test_result_holdoff();
        holdoff_request = 400;
        test_random_traffic(300, 64);
    endtask

    initial begin
        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_accesses();
        test_random_traffic(1200, 256);
        test_back_to_back();
        test_result_holdoff();

        // Drop valid and drain
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests (%0d stores), %0d results, %0d input stall cycles",
                 requests_sent, stores_sent, results_seen, backpressure_cycles);
        $display("Result status mix: %0d ok, %0d unaligned, %0d out of range",
                 status_seen[mlsm_pkg::ST_OK], status_seen[mlsm_pkg::ST_UNALIGNED],
                 status_seen[mlsm_pkg::ST_RANGE]);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: covers the clearing sweep after reset and a slow run many times over
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/mlsm_pkg.sv
hw/rtl/mlsm_ram.sv
hw/rtl/mlsm_ctrl.sv
hw/rtl/mlsm_dp.sv
hw/rtl/mips_load_store_memory_core.sv
tb/sv/tb_mips_load_store_memory_core.sv
